FILE: rtl/brsort_pkg.sv
// ----------------------------------------------------------------------------
// brsort_pkg
// Shared sizes and helpers for the binary radix sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package brsort_pkg;

  localparam int DEPTH    = 64;
  localparam int KEY_BITS = 16;

  localparam int VAL_W  = 32;
  localparam int KEY_W  = 16;
  localparam int MOVE_W = 22;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Key bits that take part in the sort
  localparam int KEY_USED = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int BIT_W    = (KEY_USED > 1) ? $clog2(KEY_USED) : 1;
  localparam int PASS_W   = $clog2(KEY_USED + 1);

  localparam logic [KEY_W-1:0] KEY_MASK =
    KEY_W'((64'(1) << KEY_USED) - 64'(1));

  // One stored entry: key above value
  localparam int ENTRY_W = KEY_W + VAL_W;

  typedef logic [ENTRY_W-1:0] entry_t;

  // Bit length of a key: position of the highest set bit plus one
  function automatic logic [PASS_W-1:0] key_bit_len(input logic [KEY_W-1:0] key);
    logic [PASS_W-1:0] len;
    len = '0;
    for (int i = 0; i < KEY_USED; i++) begin
      if (key[i]) begin
        len = PASS_W'(i + 1);
      end
    end
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/binary_radix_sort_two_stacks_top.sv
// ----------------------------------------------------------------------------
// binary_radix_sort_two_stacks_top
// Stable LSD binary radix sort of up to DEPTH keyed items over two RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_axis_*): one item per transfer, one per cycle while
//   loading. tlast marks the final item of a set and starts the sort. Items
//   past DEPTH are dropped; a dropped item with tlast still starts the sort.
//   Master channel (m_axis_*): every stored item in ascending key order, ties
//   in arrival order, each with the total move count; tlast on the last one.
//   Sorting takes B passes, B = bit length of the largest key; each pass
//   streams all n stored entries through the RAM read port, one per cycle.
//   Each result is then read, captured and transferred when the receiver
//   is ready. The slave side is held off from the last input until the
//   last result transfer.
//   Reset clears the item count and the controller; RAM contents are not
//   cleared and need no clearing pass. A stalled receiver simply holds the
//   current result in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_radix_sort_two_stacks_top
  import brsort_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tdata: item_value[31:0], sort_key[47:32]
  input  wire logic [47:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,     // load_last
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: sorted_value[31:0], sorted_key[47:32], move_count[69:48], zeros
  output logic [71:0]      m_axis_tdata,
  output logic             m_axis_tlast,     // emit_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS_RD,
    ST_PASS_END,
    ST_PASS_DONE,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT_OUT
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    cnt_q;      // items stored
  logic [CNT_W-1:0]    idx_q;      // logical read index
  logic [CNT_W-1:0]    zb_q;       // zero/one boundary of the source RAM
  logic [CNT_W-1:0]    zcnt_q;     // zeros written this pass
  logic [CNT_W-1:0]    ocnt_q;     // ones written this pass
  logic                src_q;      // RAM holding the current order
  logic [BIT_W-1:0]    bit_q;      // key bit of this pass
  logic [PASS_W-1:0]   passes_q;
  logic [MOVE_W-1:0]   moves_q;
  logic [KEY_W-1:0]    maxkey_q;
  logic                rd_vld_q;   // RAM read data belongs to this pass

  logic [VAL_W-1:0]    out_val_q;
  logic [KEY_W-1:0]    out_key_q;
  logic                out_last_q;

  // Input fields
  logic [VAL_W-1:0] in_val;
  logic [KEY_W-1:0] in_key;
  logic             in_fire;
  logic             in_store;

  assign in_val   = s_axis_tdata[VAL_W-1:0];
  assign in_key   = s_axis_tdata[VAL_W +: KEY_W] & KEY_MASK;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign in_store = in_fire && (cnt_q < CNT_W'(DEPTH));

  // Logical index to physical address: zeros sit in order from the bottom,
  // ones sit reversed from the top of the occupied range.
  logic [CNT_W:0]    phys_full;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    if (idx_q < zb_q) begin
      phys_full = {1'b0, idx_q};
    end else begin
      phys_full = {1'b0, cnt_q} - (CNT_W+1)'(1) + {1'b0, zb_q} - {1'b0, idx_q};
    end
    rd_addr = phys_full[ADDR_W-1:0];
  end

  // RAMs
  entry_t rdata0, rdata1, rdata;
  logic   we0, we1;
  logic [ADDR_W-1:0] waddr0, waddr1, pass_waddr;
  entry_t wdata0, wdata1;
  logic   rd_bit;
  logic [CNT_W-1:0] one_addr;

  assign rdata    = src_q ? rdata1 : rdata0;
  assign rd_bit   = rdata[VAL_W + int'(bit_q)];
  assign one_addr = cnt_q - CNT_W'(1) - ocnt_q;
  assign pass_waddr = rd_bit ? one_addr[ADDR_W-1:0] : zcnt_q[ADDR_W-1:0];

  always_comb begin
    // RAM 0 takes loads and passes whose source is RAM 1
    we0    = in_store || (rd_vld_q && src_q);
    waddr0 = in_store ? cnt_q[ADDR_W-1:0] : pass_waddr;
    wdata0 = in_store ? {in_key, in_val} : rdata;
    we1    = rd_vld_q && !src_q;
    waddr1 = pass_waddr;
    wdata1 = rdata;
  end

  brsort_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (waddr0),
    .wdata_i (wdata0),
    .raddr_i (rd_addr),
    .rdata_o (rdata0)
  );

  brsort_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (waddr1),
    .wdata_i (wdata1),
    .raddr_i (rd_addr),
    .rdata_o (rdata1)
  );

  // Values taken at the start of a sort
  logic [CNT_W-1:0]  n_start;
  logic [KEY_W-1:0]  max_start;
  logic [PASS_W-1:0] passes_start;

  assign n_start      = in_store ? cnt_q + CNT_W'(1) : cnt_q;
  assign max_start    = (in_store && in_key > maxkey_q) ? in_key : maxkey_q;
  assign passes_start = key_bit_len(max_start);

  logic last_pass;
  assign last_pass = (PASS_W'(bit_q) + PASS_W'(1)) == passes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      cnt_q      <= '0;
      idx_q      <= '0;
      zb_q       <= '0;
      zcnt_q     <= '0;
      ocnt_q     <= '0;
      src_q      <= 1'b0;
      bit_q      <= '0;
      passes_q   <= '0;
      moves_q    <= '0;
      maxkey_q   <= '0;
      rd_vld_q   <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      // Issue one read a cycle during a pass; the write follows in the next cycle
      rd_vld_q <= (state_q == ST_PASS_RD) && (idx_q < cnt_q);
      case (state_q)
        ST_LOAD: begin
          if (in_store) begin
            cnt_q    <= n_start;
            maxkey_q <= max_start;
          end
          if (in_fire && s_axis_tlast) begin
            idx_q    <= '0;
            zb_q     <= n_start;
            zcnt_q   <= '0;
            ocnt_q   <= '0;
            src_q    <= 1'b0;
            bit_q    <= '0;
            passes_q <= passes_start;
            moves_q  <= '0;
            state_q  <= (passes_start == '0) ? ST_EMIT_RD : ST_PASS_RD;
          end
        end
        ST_PASS_RD: begin
          if (idx_q < cnt_q) begin
            idx_q <= idx_q + CNT_W'(1);
          end else begin
            state_q <= ST_PASS_END;
          end
        end
        ST_PASS_END: begin
          state_q <= ST_PASS_DONE;
        end
        ST_PASS_DONE: begin
          moves_q <= moves_q + MOVE_W'(cnt_q) + MOVE_W'(zcnt_q);
          zb_q    <= zcnt_q;
          src_q   <= !src_q;
          idx_q   <= '0;
          zcnt_q  <= '0;
          ocnt_q  <= '0;
          bit_q   <= bit_q + BIT_W'(1);
          state_q <= last_pass ? ST_EMIT_RD : ST_PASS_RD;
        end
        ST_EMIT_RD: begin
          state_q <= ST_EMIT_WAIT;
        end
        ST_EMIT_WAIT: begin
          out_last_q <= (idx_q + CNT_W'(1)) == cnt_q;
          state_q    <= ST_EMIT_OUT;
        end
        ST_EMIT_OUT: begin
          if (m_axis_tready) begin
            if (out_last_q) begin
              cnt_q    <= '0;
              maxkey_q <= '0;
              state_q  <= ST_LOAD;
            end else begin
              idx_q   <= idx_q + CNT_W'(1);
              state_q <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase

      // Advance the write pointers as pass data lands
      if (rd_vld_q) begin
        if (rd_bit) begin
          ocnt_q <= ocnt_q + CNT_W'(1);
        end else begin
          zcnt_q <= zcnt_q + CNT_W'(1);
        end
      end
    end
  end

  // Output payload, captured once the read data is back
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT_WAIT) begin
      out_val_q <= rdata[VAL_W-1:0];
      out_key_q <= rdata[VAL_W +: KEY_W];
    end
  end

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = (state_q == ST_EMIT_OUT);
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, moves_q, out_key_q, out_val_q};

  // Assertions
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("load and emit active together");

  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (zcnt_q + ocnt_q) <= cnt_q)
    else $error("pass wrote more entries than stored");

  a_pass_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PASS_DONE |-> !rd_vld_q && (zcnt_q + ocnt_q) == cnt_q)
    else $error("pass closed with writes outstanding");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("item count beyond depth");

endmodule

`default_nettype wire

FILE: rtl/brsort_ram.sv
// ----------------------------------------------------------------------------
// brsort_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module brsort_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AW-1:0]            waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [AW-1:0]            raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: tb/binary_radix_sort_two_stacks_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_radix_sort_two_stacks_checker
// Watches both stream channels of the radix sorter, rebuilds every sorted run
// from the accepted items and compares each result transfer field by field.
// ----------------------------------------------------------------------------

module binary_radix_sort_two_stacks_checker
  import brsort_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: item_value[31:0], sort_key[47:32]
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tlast,     // load_last
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // tdata: sorted_value[31:0], sorted_key[47:32], move_count[69:48], zeros
  input  logic [71:0] m_axis_tdata,
  input  logic        m_axis_tlast,     // emit_last
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output int          fail_count_o,
  output int          pending_results_o
);

  localparam int PAD_LSB = VAL_W + KEY_W + MOVE_W;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [KEY_W-1:0]  key;
    logic [MOVE_W-1:0] moves;
    logic              last;
  } sorted_item_t;

  // Items of the set being loaded, in stack order once sorted
  logic [KEY_W-1:0] held_key [DEPTH];
  logic [VAL_W-1:0] held_val [DEPTH];
  int               held_n = 0;

  int               fail_count      = 0;
  int               pending_results = 0;

  sorted_item_t sorted_q [$];

  assign fail_count_o      = fail_count;
  assign pending_results_o = pending_results;

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [KEY_W-1:0]  zero_key [DEPTH];
    logic [VAL_W-1:0]  zero_val [DEPTH];
    logic [KEY_W-1:0]  one_key  [DEPTH];
    logic [VAL_W-1:0]  one_val  [DEPTH];
    logic [KEY_W-1:0]  top_key;
    logic [MOVE_W-1:0] moves;
    int                passes;
    int                n_zero;
    int                n_one;
    sorted_item_t      want;
    if (!rst_ni) begin
      held_n = 0;
      sorted_q.delete();
      pending_results = 0;
    end else begin
      // Compare a result transfer with the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        if (sorted_q.size() == 0) begin
          $error("unexpected result: value %h key %h moves %h last %b",
                 m_axis_tdata[VAL_W-1:0], m_axis_tdata[VAL_W+KEY_W-1:VAL_W],
                 m_axis_tdata[PAD_LSB-1:VAL_W+KEY_W], m_axis_tlast);
          fail_count++;
        end else begin
          want = sorted_q.pop_front();
          if (m_axis_tdata[VAL_W-1:0] !== want.value) begin
            $error("sorted_value: expected %h, actual %h",
                   want.value, m_axis_tdata[VAL_W-1:0]);
            fail_count++;
          end
          if (m_axis_tdata[VAL_W+KEY_W-1:VAL_W] !== want.key) begin
            $error("sorted_key: expected %h, actual %h",
                   want.key, m_axis_tdata[VAL_W+KEY_W-1:VAL_W]);
            fail_count++;
          end
          if (m_axis_tdata[PAD_LSB-1:VAL_W+KEY_W] !== want.moves) begin
            $error("move_count: expected %0d, actual %0d",
                   want.moves, m_axis_tdata[PAD_LSB-1:VAL_W+KEY_W]);
            fail_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("emit_last: expected %b, actual %b", want.last, m_axis_tlast);
            fail_count++;
          end
          if (m_axis_tdata[71:PAD_LSB] !== '0) begin
            $error("tdata padding: expected %h, actual %h",
                   2'b00, m_axis_tdata[71:PAD_LSB]);
            fail_count++;
          end
        end
      end

      // Store an item transfer; a full set drops it
      if (s_axis_tvalid && s_axis_tready) begin
        if (held_n < DEPTH) begin
          held_val[held_n] = s_axis_tdata[VAL_W-1:0];
          held_key[held_n] = s_axis_tdata[VAL_W+KEY_W-1:VAL_W] & KEY_MASK;
          held_n++;
        end
        if (s_axis_tlast) begin
          // Number of passes is the bit length of the largest key
          top_key = '0;
          for (int k = 0; k < held_n; k++) begin
            if (held_key[k] > top_key) begin
              top_key = held_key[k];
            end
          end
          passes = 0;
          while ((top_key >> passes) != 0) begin
            passes++;
          end
          // Each pass: zeros end up on top in order, ones below in order
          moves = '0;
          for (int b = 0; b < passes; b++) begin
            n_zero = 0;
            n_one  = 0;
            for (int k = 0; k < held_n; k++) begin
              if (held_key[k][b]) begin
                one_key[n_one] = held_key[k];
                one_val[n_one] = held_val[k];
                n_one++;
              end else begin
                zero_key[n_zero] = held_key[k];
                zero_val[n_zero] = held_val[k];
                n_zero++;
              end
            end
            for (int k = 0; k < n_zero; k++) begin
              held_key[k] = zero_key[k];
              held_val[k] = zero_val[k];
            end
            for (int k = 0; k < n_one; k++) begin
              held_key[n_zero + k] = one_key[k];
              held_val[n_zero + k] = one_val[k];
            end
            // every item rotates or is pushed, and every zero comes back
            moves += MOVE_W'(held_n + n_zero);
          end
          for (int k = 0; k < held_n; k++) begin
            want.value = held_val[k];
            want.key   = held_key[k];
            want.moves = moves;
            want.last  = (k == held_n - 1);
            sorted_q.push_back(want);
          end
          held_n = 0;
        end
      end
      pending_results = sorted_q.size();
    end
  end

endmodule

FILE: tb/binary_radix_sort_two_stacks_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_radix_sort_two_stacks_top_tb
// Feeds keyed item sets to the radix sorter under several idle and stall
// patterns; a separate checker predicts and compares every sorted result.
// ----------------------------------------------------------------------------

module binary_radix_sort_two_stacks_top_tb;
  import brsort_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int HOLD_OFF_CYCLES = 2500;
  // Quiet stretch after the last drain, for any stray result to show up
  localparam int SETTLE_CYCLES   = 200;

  typedef enum int {
    KEYS_FULL,
    KEYS_NARROW,
    KEYS_ZERO,
    KEYS_SHIFTED
  } key_mix_e;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic [47:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;

  int   fail_count;
  int   pending_results;

  // Idle shares in percent for each side
  int   src_idle_pct   = 0;
  int   sink_stall_pct = 0;
  // Toggle to start one long receiver hold-off
  logic hold_off_req   = 1'b0;
  int   stored_items   = 0;
  int   cycle_count    = 0;

  binary_radix_sort_two_stacks_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  binary_radix_sort_two_stacks_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tlast      (s_axis_tlast),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tlast      (m_axis_tlast),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .fail_count_o      (fail_count),
    .pending_results_o (pending_results)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Abort a run that hangs
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("binary_radix_sort_two_stacks_top test failed");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off counted here
  initial begin : sink_drive
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req != hold_seen) begin
        hold_seen = hold_off_req;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Offer one item; enter and leave at a falling edge, valid stays high
  task automatic send_item(input logic [VAL_W-1:0] value, input logic [KEY_W-1:0] key,
                           input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {key, value};
    s_axis_tlast  <= last;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every expected result has arrived
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do begin
      @(negedge clk_i);
    end while (pending_results != 0);
  endtask

  // One set of n items, tlast on the final one; past DEPTH the block drops
  task automatic send_set(input int n, input key_mix_e mix);
    int               shift;
    logic [KEY_W-1:0] key;
    shift = $urandom_range(KEY_W - 1);
    for (int i = 0; i < n; i++) begin
      case (mix)
        KEYS_FULL:   key = KEY_W'($urandom);
        KEYS_NARROW: key = KEY_W'($urandom_range(15));
        KEYS_ZERO:   key = '0;
        default:     key = KEY_W'($urandom) >> shift;
      endcase
      send_item($urandom, key, i == n - 1);
    end
    stored_items += (n < DEPTH) ? n : DEPTH;
  endtask

  initial begin : stimulus
    int       phase_start;
    int       set_n;
    int       pick;
    key_mix_e mix;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Single item, widest key, most negative value: all sixteen passes
    send_item(32'h8000_0000, 16'hFFFF, 1'b1);
    // All keys zero: no pass, arrival order, zero moves
    send_item(32'h7FFF_FFFF, 16'h0000, 1'b0);
    send_item(32'h0000_0000, 16'h0000, 1'b0);
    send_item(32'hFFFF_FFFF, 16'h0000, 1'b1);
    // Extremes with ties that must keep arrival order
    send_item(32'h0000_0001, 16'hFFFF, 1'b0);
    send_item(32'hFFFF_FFFE, 16'h0000, 1'b0);
    send_item(32'h5555_5555, 16'h8000, 1'b0);
    send_item(32'hAAAA_AAAA, 16'h0001, 1'b0);
    send_item(32'h7FFF_FFFF, 16'hFFFF, 1'b0);
    send_item(32'h8000_0000, 16'h0000, 1'b1);
    // Lone zero key
    send_item(32'h0000_0000, 16'h0000, 1'b1);
    // Alternating bit patterns
    send_item(32'h1234_5678, 16'h5555, 1'b0);
    send_item(32'h9ABC_DEF0, 16'hAAAA, 1'b0);
    send_item(32'h0F0F_0F0F, 16'h0001, 1'b0);
    send_item(32'hF0F0_F0F0, 16'h0002, 1'b1);
    wait_drain();

    // Phases: none, sender idle, receiver stall, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct <= 0;
        end
        1: begin
          src_idle_pct   = 50;
          sink_stall_pct <= 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct <= 50;
        end
        default: begin
          src_idle_pct   = 35;
          sink_stall_pct <= 35;
        end
      endcase
      phase_start = stored_items;

      // Full store at the start of the first phase, overflow in the last
      if (phase == 0) begin
        send_set(DEPTH, KEYS_FULL);
      end
      if (phase == 3) begin
        send_set(DEPTH + 2, KEYS_FULL);
      end
      // Hold the receiver off while sets keep coming, so the input stalls
      if (phase == 2) begin
        hold_off_req <= ~hold_off_req;
      end

      while (stored_items - phase_start < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          set_n = $urandom_range(8, 1);
        end else if (pick < 90) begin
          set_n = $urandom_range(24, 9);
        end else if (pick < 96) begin
          set_n = $urandom_range(DEPTH, DEPTH - 4);
        end else begin
          set_n = $urandom_range(DEPTH + 6, DEPTH + 1);
        end
        pick = $urandom_range(99);
        if (pick < 50) begin
          mix = KEYS_FULL;
        end else if (pick < 70) begin
          mix = KEYS_NARROW;
        end else if (pick < 80) begin
          mix = KEYS_ZERO;
        end else begin
          mix = KEYS_SHIFTED;
        end
        send_set(set_n, mix);
      end
      // Pause the sender until the block has emitted everything
      wait_drain();
    end

    // Leave time for any stray result to show up
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("binary_radix_sort_two_stacks_top test passed");
    end else begin
      $display("binary_radix_sort_two_stacks_top test failed");
    end
    $finish;
  end

endmodule
